// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the allocator rtl
// expects clk_i and rst_ni in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock outside reset
`define FBPA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("fbpa assertion failed");

// consequent checked in the cycle after the antecedent
`define FBPA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fbpa assertion failed");

`endif

// ===== hw/rtl/fbpa_pkg.sv =====
// fbpa_pkg: pool geometry, codes and shared types of the block allocator
// no dependencies
package fbpa_pkg;

  localparam int NumBlocks  = 32;
  localparam int BlockBytes = 128;
  localparam int AddrW      = 32;
  localparam int IdxW       = $clog2(NumBlocks);
  localparam int BlockShift = $clog2(BlockBytes);

  // pool size in bytes, one bit wider than an address
  localparam logic [AddrW:0] PoolBytes = (AddrW + 1)'(NumBlocks * BlockBytes);

  typedef enum logic {
    CmdAlloc = 1'b0,
    CmdFree  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StError = 2'd2
  } status_e;

  // request presented to the free list
  typedef struct packed {
    logic            fire;
    cmd_e            cmd;
    logic            in_range;
    logic [IdxW-1:0] rel_idx;
  } fbpa_op_t;

  // outcome of a request
  typedef struct packed {
    status_e         status;
    logic [IdxW-1:0] grant_idx;
  } fbpa_res_t;

endpackage

// ===== hw/rtl/fixed_block_pool_allocator.sv =====
// fixed_block_pool_allocator: 1 request per cycle sustained while the receiver takes each result;
// an input register and a result register bracket one pass through the free list
// the free list head, read and written every cycle, sets the single-cycle rate
// reset: async active low; pool base 0, chain from highest index down to 0, bitmap clear
// depends on fbpa_pkg, fbpa_free_list and assert_macros.svh
`include "assert_macros.svh"

module fixed_block_pool_allocator import fbpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [AddrW-1:0] cfg_pool_base_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             command_i,
  input  logic [AddrW-1:0] address_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [AddrW-1:0] block_address_o,
  output logic [1:0]       status_o
);

  logic [AddrW-1:0] pool_base_q;
  logic             s1_valid_q;
  cmd_e             s1_cmd_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             out_valid_q;
  logic [AddrW-1:0] out_addr_q, out_addr_d;
  status_e          out_status_q;
  logic             advance;
  logic             s1_load;
  logic [AddrW-1:0] offset;
  fbpa_op_t         op;
  fbpa_res_t        res;

  assign cfg_ready_o = 1'b1;
  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || advance;
  assign s1_load     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pool_base_q <= cfg_pool_base_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_cmd_q  <= cmd_e'(command_i);
      s1_addr_q <= address_i;
    end
  end

  // release address to block index
  assign offset      = s1_addr_q - pool_base_q;
  assign op.fire     = s1_valid_q && advance;
  assign op.cmd      = s1_cmd_q;
  assign op.in_range = {1'b0, offset} < PoolBytes;
  assign op.rel_idx  = offset[BlockShift +: IdxW];

  fbpa_free_list u_free_list (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .res_o  (res)
  );

  always_comb begin
    out_addr_d = '0;
    if (s1_cmd_q == CmdAlloc && res.status == StOk) begin
      out_addr_d = pool_base_q + (AddrW'(res.grant_idx) << BlockShift);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op.fire) begin
      out_addr_q   <= out_addr_d;
      out_status_q <= res.status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign block_address_o = out_addr_q;
  assign status_o        = out_status_q;

  `FBPA_ASSERT(a_fail_zero_addr, out_valid_q && out_status_q != StOk |-> out_addr_q == '0)

endmodule

// ===== hw/rtl/fbpa_free_list.sv =====
// fbpa_free_list: lifo free list of block indices and allocation bitmap
// depends on fbpa_pkg and assert_macros.svh
`include "assert_macros.svh"

module fbpa_free_list import fbpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fbpa_op_t  op_i,
  output fbpa_res_t res_o
);

  logic [IdxW-1:0]      head_q, head_d;
  logic                 head_vld_q, head_vld_d;
  logic [NumBlocks-1:0] map_q, map_d;
  logic [IdxW-1:0]      link_idx_q [NumBlocks];
  logic                 link_vld_q [NumBlocks];
  logic                 link_we;
  logic                 rel_ok;

  assign rel_ok = op_i.in_range && map_q[op_i.rel_idx];

  always_comb begin
    res_o.grant_idx = head_q;
    res_o.status    = StOk;
    head_d          = head_q;
    head_vld_d      = head_vld_q;
    map_d           = map_q;
    link_we         = 1'b0;
    case (op_i.cmd)
      CmdAlloc: begin
        res_o.status = head_vld_q ? StOk : StEmpty;
        if (op_i.fire && head_vld_q) begin
          head_d         = link_idx_q[head_q];
          head_vld_d     = link_vld_q[head_q];
          map_d[head_q]  = 1'b1;
        end
      end
      CmdFree: begin
        res_o.status = rel_ok ? StOk : StError;
        if (op_i.fire && rel_ok) begin
          link_we              = 1'b1;
          head_d               = op_i.rel_idx;
          head_vld_d           = 1'b1;
          map_d[op_i.rel_idx]  = 1'b0;
        end
      end
      default: begin
        res_o.status = StError;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= IdxW'(NumBlocks - 1);
      head_vld_q <= 1'b1;
      map_q      <= '0;
    end else begin
      head_q     <= head_d;
      head_vld_q <= head_vld_d;
      map_q      <= map_d;
    end
  end

  // reset chain runs from the top index down to 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBlocks; i++) begin
        link_idx_q[i] <= (i > 0) ? IdxW'(i - 1) : '0;
        link_vld_q[i] <= (i > 0);
      end
    end else if (link_we) begin
      link_idx_q[op_i.rel_idx] <= head_q;
      link_vld_q[op_i.rel_idx] <= head_vld_q;
    end
  end

  `FBPA_ASSERT(a_head_is_free, head_vld_q |-> !map_q[head_q])
  `FBPA_ASSERT_NEXT(a_grant_marks, op_i.fire && op_i.cmd == CmdAlloc && head_vld_q, map_q[$past(head_q)])
  `FBPA_ASSERT_NEXT(a_fail_holds, op_i.fire && res_o.status != StOk, $stable(map_q) && $stable(head_q) && $stable(head_vld_q))

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for fixed_block_pool_allocator
// predicts each grant and release outcome from its own copy of the free list and bitmap
// depends on fbpa_pkg and the allocator rtl
module tb_top;
  import fbpa_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 4;
  localparam int PhaseItems  = 200;
  localparam int MaxPrints   = 40;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    status_e          status;
  } grant_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [AddrW-1:0] cfg_base = '0;
  logic             in_valid = 1'b0;
  cmd_e             cmd_drv = CmdAlloc;
  logic [AddrW-1:0] addr_drv = '0;
  logic             out_ready = 1'b0;
  logic             cfg_ready_o;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [AddrW-1:0] block_address_o;
  logic [1:0]       status_o;

  // predictor state
  logic [AddrW-1:0] pool_base_cfg;
  logic [IdxW-1:0]  head_idx;
  logic             head_live;
  logic [IdxW-1:0]  link_idx [NumBlocks];
  logic             link_live [NumBlocks];
  logic [NumBlocks-1:0] busy_map;

  grant_t      pending_grants[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  logic [15:0] stall_pat = 16'hFFFF;

  fixed_block_pool_allocator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_pool_base_i (cfg_base),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .command_i       (cmd_drv),
    .address_i       (addr_drv),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .block_address_o (block_address_o),
    .status_o        (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void reset_pool_model();
    pool_base_cfg = '0;
    for (int i = 0; i < NumBlocks; i++) begin
      link_idx[i]  = (i > 0) ? IdxW'(i - 1) : '0;
      link_live[i] = (i > 0);
    end
    head_idx  = IdxW'(NumBlocks - 1);
    head_live = 1'b1;
    busy_map  = '0;
  endfunction

  function automatic grant_t pool_step(input cmd_e cmd, input logic [AddrW-1:0] addr);
    grant_t           g;
    logic [IdxW-1:0]  idx;
    logic [AddrW-1:0] offset;
    logic [AddrW-1:0] blk;
    g.addr = '0;
    if (cmd == CmdAlloc) begin
      if (head_live) begin
        idx = head_idx;
        g.addr = pool_base_cfg + AddrW'(idx) * AddrW'(BlockBytes);
        g.status = StOk;
        head_live = link_live[idx];
        head_idx = link_idx[idx];
        busy_map[idx] = 1'b1;
      end else begin
        g.status = StEmpty;
      end
    end else begin
      offset = addr - pool_base_cfg;
      blk = offset / AddrW'(BlockBytes);
      if (blk < AddrW'(NumBlocks) && busy_map[blk[IdxW-1:0]]) begin
        idx = blk[IdxW-1:0];
        link_idx[idx] = head_idx;
        link_live[idx] = head_live;
        head_idx = idx;
        head_live = 1'b1;
        busy_map[idx] = 1'b0;
        g.status = StOk;
      end else begin
        g.status = StError;
      end
    end
    return g;
  endfunction

  function automatic int pick_busy_block();
    int start;
    int idx;
    start = $urandom_range(0, NumBlocks - 1);
    for (int i = 0; i < NumBlocks; i++) begin
      idx = (start + i) % NumBlocks;
      if (busy_map[idx]) return idx;
    end
    return -1;
  endfunction

  function automatic logic [AddrW-1:0] block_addr(input int idx, input int unsigned off);
    return pool_base_cfg + AddrW'(idx) * AddrW'(BlockBytes) + AddrW'(off);
  endfunction

  task automatic report_mismatch(input string what, input logic [AddrW-1:0] got,
                                 input logic [AddrW-1:0] want);
    if (mismatch_count < MaxPrints)
      $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // bursts of requests with random gaps in between
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_request(input cmd_e cmd, input logic [AddrW-1:0] addr);
    pace_sender();
    in_valid <= 1'b1;
    cmd_drv  <= cmd;
    addr_drv <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    pending_grants.push_back(pool_step(cmd, addr));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_pool_base(input logic [AddrW-1:0] base);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_base  <= base;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    pool_base_cfg = base;
  endtask

  task automatic test_directed_cases();
    send_request(CmdFree, 32'h0000_0000);
    send_request(CmdAlloc, 32'hFFFF_FFFF);
    send_request(CmdAlloc, 32'h0000_0000);
    send_request(CmdFree, block_addr(NumBlocks - 1, BlockBytes - 1));
    send_request(CmdFree, block_addr(NumBlocks - 1, 0));
    send_request(CmdAlloc, $urandom());
    send_request(CmdFree, block_addr(NumBlocks, 0));
    send_request(CmdFree, 32'hFFFF_FFFF);
    send_request(CmdFree, block_addr(NumBlocks - 2, 0));
    send_request(CmdFree, block_addr(NumBlocks - 1, BlockBytes / 2));
    send_request(CmdAlloc, $urandom());
    send_request(CmdAlloc, $urandom());
    // pool that wraps past the top of the address space
    set_pool_base(32'hFFFF_FFC0);
    send_request(CmdAlloc, $urandom());
    send_request(CmdFree, block_addr(NumBlocks - 3, 1));
    send_request(CmdFree, 32'h0000_0000);
    send_request(CmdFree, pool_base_cfg - 1);
    send_request(CmdFree, block_addr(NumBlocks - 1, 3));
    send_request(CmdFree, block_addr(NumBlocks - 2, BlockBytes - 1));
  endtask

  task automatic test_pool_exhaust();
    int idx;
    set_pool_base($urandom() & ~(AddrW'(BlockBytes) - 1));
    repeat (NumBlocks + 4) send_request(CmdAlloc, $urandom());
    idx = pick_busy_block();
    while (idx >= 0) begin
      send_request(CmdFree, block_addr(idx, $urandom_range(0, BlockBytes - 1)));
      idx = pick_busy_block();
    end
    send_request(CmdFree, block_addr($urandom_range(0, NumBlocks - 1), 0));
  endtask

  task automatic test_random_traffic(input logic [AddrW-1:0] base, input int items);
    int sent;
    int kind;
    int run;
    int idx;
    logic [AddrW-1:0] addr;
    set_pool_base(base);
    sent = 0;
    while (sent < items) begin
      if (sent >= items / 2 && sent < items / 2 + 8) wait_drained();
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        run = (kind == 0) ? $urandom_range(1, NumBlocks + 8) : $urandom_range(1, 6);
        repeat (run) send_request(CmdAlloc, $urandom());
        sent += run;
      end else if (kind <= 6) begin
        run = $urandom_range(1, 8);
        repeat (run) begin
          idx = pick_busy_block();
          if (idx >= 0) begin
            send_request(CmdFree, block_addr(idx, $urandom_range(0, BlockBytes - 1)));
            sent++;
          end
        end
      end else if (kind == 7) begin
        idx = $urandom_range(0, NumBlocks - 1);
        send_request(CmdFree, block_addr(idx, $urandom_range(0, BlockBytes - 1)));
        send_request(CmdFree, block_addr(idx, $urandom_range(0, BlockBytes - 1)));
        sent += 2;
      end else begin
        case ($urandom_range(0, 3))
          0: addr = $urandom();
          1: addr = pool_base_cfg - AddrW'($urandom_range(1, 1 << 16));
          2: addr = block_addr(NumBlocks, $urandom_range(0, 1 << 16));
          default: addr = ~pool_base_cfg;
        endcase
        send_request(CmdFree, addr);
        sent++;
      end
    end
  endtask

  // result check against the oldest pending grant
  always @(posedge clk_i) begin : check_results
    grant_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("unexpected result", block_address_o, '0);
      end else begin
        want = pending_grants.pop_front();
        if (block_address_o !== want.addr)
          report_mismatch("block_address", block_address_o, want.addr);
        if (status_o !== want.status)
          report_mismatch("status", AddrW'(status_o), AddrW'(want.status));
      end
    end
  end

  // receiver stalls follow a rotating pattern
  always @(posedge clk_i) begin : drive_ready
    if (cycle_count % 32 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pat = 16'hFFFF;
        1: stall_pat = 16'($urandom());
        2: stall_pat = 16'($urandom()) | 16'($urandom());
        default: stall_pat = 16'h8000;
      endcase
    end
    out_ready <= stall_pat[cycle_count % 16];
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    reset_pool_model();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_pool_exhaust();
    test_random_traffic(32'h0000_0000, PhaseItems);
    test_random_traffic(32'hFFFF_FFFF, PhaseItems);
    test_random_traffic(32'hFFFF_F800, PhaseItems);
    test_random_traffic($urandom(), PhaseItems);
    test_random_traffic($urandom() & ~(AddrW'(BlockBytes) - 1), PhaseItems);
    test_random_traffic(32'h8000_0000, PhaseItems);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
